FILE: sv/arp_pkg.sv
// Shared types and codes for the AArch64 relocation patcher.
package arp_pkg;

    localparam logic [4:0] CMD_UNSUP      = 5'd0;
    localparam logic [4:0] CMD_ABS64      = 5'd1;
    localparam logic [4:0] CMD_ABS32      = 5'd2;
    localparam logic [4:0] CMD_ABS16      = 5'd3;
    localparam logic [4:0] CMD_PREL64     = 5'd4;
    localparam logic [4:0] CMD_PREL32     = 5'd5;
    localparam logic [4:0] CMD_PREL16     = 5'd6;
    localparam logic [4:0] CMD_TP_G2      = 5'd7;
    localparam logic [4:0] CMD_TP_G1      = 5'd8;
    localparam logic [4:0] CMD_TP_G0      = 5'd9;
    localparam logic [4:0] CMD_TP_HI12    = 5'd10;
    localparam logic [4:0] CMD_TP_LO12_S0 = 5'd11;
    localparam logic [4:0] CMD_TP_LO12_S1 = 5'd12;
    localparam logic [4:0] CMD_TP_LO12_S2 = 5'd13;
    localparam logic [4:0] CMD_TP_LO12_S3 = 5'd14;
    localparam logic [4:0] CMD_TP_LO12_S4 = 5'd15;
    localparam logic [4:0] CMD_TPREL64    = 5'd16;
    localparam logic [4:0] CMD_ADR_LO21   = 5'd17;
    localparam logic [4:0] CMD_ADRP       = 5'd18;
    localparam logic [4:0] CMD_ADD_LO12   = 5'd19;
    localparam logic [4:0] CMD_LDST_S0    = 5'd20;
    localparam logic [4:0] CMD_LDST_S1    = 5'd21;
    localparam logic [4:0] CMD_LDST_S2    = 5'd22;
    localparam logic [4:0] CMD_LDST_S3    = 5'd23;
    localparam logic [4:0] CMD_LDST_S4    = 5'd24;
    localparam logic [4:0] CMD_BRANCH26   = 5'd25;
    localparam logic [4:0] CMD_CALL_PLT   = 5'd26;
    localparam logic [4:0] CMD_GOT_PAGE   = 5'd27;
    localparam logic [4:0] CMD_NOP        = 5'd28;

    localparam logic [1:0] WW_NONE = 2'd0;
    localparam logic [1:0] WW_16   = 2'd1;
    localparam logic [1:0] WW_32   = 2'd2;
    localparam logic [1:0] WW_64   = 2'd3;

    localparam logic [1:0] ST_PATCHED  = 2'd0;
    localparam logic [1:0] ST_DONE     = 2'd1;
    localparam logic [1:0] ST_UNSUP    = 2'd2;
    localparam logic [1:0] ST_NO_GOT   = 2'd3;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GOT_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GOT_PRESENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLT_BASE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLT_PRESENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TCB_SIZE    = 3'd4;

    localparam logic [7:0] TCB_SIZE_RESET = 8'd16;

    typedef struct packed {
        logic [63:0] new_value;
        logic [1:0]  write_width;
        logic [1:0]  status;
    } t_res;

endpackage

FILE: sv/arp_ifs.sv
// Handshake channels of the relocation patcher: input words, results, configuration.
interface arp_in_if;
    logic               valid;
    logic               ready;
    logic [4:0]         cmd;
    logic [63:0]        sym_addr;
    logic signed [63:0] addend;
    logic [63:0]        place;
    logic [31:0]        old_word;
    logic signed [16:0] got_slot;
    logic signed [16:0] plt_slot;

    modport source (output valid, cmd, sym_addr, addend, place, old_word, got_slot,
                    plt_slot, input ready);
    modport sink (input valid, cmd, sym_addr, addend, place, old_word, got_slot,
                  plt_slot, output ready);
endinterface

interface arp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] new_value;
    logic [1:0]  write_width;
    logic [1:0]  status;

    modport source (output valid, new_value, write_width, status, input ready);
    modport sink (input valid, new_value, write_width, status, output ready);
endinterface

interface arp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/aarch64_relocation_patcher_core.sv
// Top level of the AArch64 relocation patcher: configuration registers and pipeline.
//
// Each input word on i_rel is one relocation record; each output word on o_res
// is its result: the value to store, the store width and a status. i_cfg writes
// the five configuration registers by index; writes to other indexes are
// dropped and the channel is always ready. Configuration must be written only
// while no record is in flight; the block itself does not enforce this.
// The pipeline has four register stages: symbol sums, target select and add,
// place subtract, and the result register. A record passes through them in
// that order and leaves on o_res from the result register; one record is
// accepted every cycle while o_res is not stalled. Each stage holds while the
// stage after it is full and stalled. When every stage holds a word, i_rel.ready
// follows o_res.ready in the same cycle; an empty stage lets one more word in
// first. Nothing is lost or repeated. Reset empties the pipeline, clears the
// GOT and PLT registers and sets the thread control block size to 16.
module aarch64_relocation_patcher_core
    import arp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    arp_cfg_if.sink      i_cfg,
    arp_in_if.sink       i_rel,
    arp_out_if.source    o_res
);

    logic [63:0] r_got_base;
    logic        r_got_present;
    logic [63:0] r_plt_base;
    logic        r_plt_present;
    logic [7:0]  r_tcb_size;

    logic        r_v1, r_v2, r_v3, r_v4;
    logic        en1, en2, en3, en4;

    logic [4:0]  r_s1_cmd;
    logic [63:0] r_s1_sa, r_s1_a, r_s1_p, r_s1_gbo, r_s1_pbo;
    logic [31:0] r_s1_old;
    logic        r_s1_gneg, r_s1_pneg;

    logic [4:0]  r_s2_cmd;
    logic [63:0] r_s2_t, r_s2_p;
    logic [31:0] r_s2_old;
    logic [63:0] n_s2_x, n_s2_y;

    logic [4:0]  r_s3_cmd;
    logic [63:0] r_s3_t, r_s3_d;
    logic [31:0] r_s3_old;
    logic [63:0] n_s3_t, n_s3_p;

    t_res        n_res;
    t_res        r_res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_got_base    <= '0;
            r_got_present <= 1'b0;
            r_plt_base    <= '0;
            r_plt_present <= 1'b0;
            r_tcb_size    <= TCB_SIZE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_GOT_BASE:    r_got_base    <= i_cfg.data;
                REG_GOT_PRESENT: r_got_present <= i_cfg.data[0];
                REG_PLT_BASE:    r_plt_base    <= i_cfg.data;
                REG_PLT_PRESENT: r_plt_present <= i_cfg.data[0];
                REG_TCB_SIZE:    r_tcb_size    <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign en4 = !r_v4 || o_res.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_rel.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_rel.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_cmd  <= i_rel.cmd;
            r_s1_sa   <= i_rel.sym_addr + i_rel.addend;
            r_s1_a    <= i_rel.addend;
            r_s1_p    <= i_rel.place;
            r_s1_old  <= i_rel.old_word;
            r_s1_gbo  <= r_got_base + {{44{i_rel.got_slot[16]}}, i_rel.got_slot, 3'b000};
            r_s1_pbo  <= r_plt_base + {{43{i_rel.plt_slot[16]}}, i_rel.plt_slot, 4'b0000};
            r_s1_gneg <= i_rel.got_slot[16];
            r_s1_pneg <= i_rel.plt_slot[16];
        end
    end

    always_comb begin
        n_s2_x = r_s1_sa;
        n_s2_y = '0;
        case (r_s1_cmd)
            CMD_TP_G2, CMD_TP_G1, CMD_TP_G0, CMD_TP_HI12, CMD_TP_LO12_S0,
            CMD_TP_LO12_S1, CMD_TP_LO12_S2, CMD_TP_LO12_S3, CMD_TP_LO12_S4,
            CMD_TPREL64: begin
                n_s2_y = {56'd0, r_tcb_size};
            end
            CMD_ADRP: begin
                if (!r_s1_gneg && r_got_present) begin
                    n_s2_x = r_s1_gbo;
                    n_s2_y = r_s1_a;
                end
            end
            CMD_GOT_PAGE: begin
                n_s2_x = r_s1_gbo;
                n_s2_y = r_s1_a;
            end
            CMD_CALL_PLT: begin
                if (r_plt_present && !r_s1_pneg) begin
                    n_s2_x = r_s1_pbo;
                    n_s2_y = r_s1_a;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_cmd <= r_s1_cmd;
            r_s2_t   <= n_s2_x + n_s2_y;
            r_s2_p   <= r_s1_p;
            r_s2_old <= r_s1_old;
        end
    end

    always_comb begin
        n_s3_t = r_s2_t;
        n_s3_p = r_s2_p;
        if (r_s2_cmd == CMD_ADRP || r_s2_cmd == CMD_GOT_PAGE) begin
            n_s3_t = {r_s2_t[63:12], 12'd0};
            n_s3_p = {r_s2_p[63:12], 12'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_cmd <= r_s2_cmd;
            r_s3_t   <= r_s2_t;
            r_s3_d   <= n_s3_t - n_s3_p;
            r_s3_old <= r_s2_old;
        end
    end

    arp_fmt u_fmt (
        .i_cmd         (r_s3_cmd),
        .i_t           (r_s3_t),
        .i_d           (r_s3_d),
        .i_old         (r_s3_old),
        .i_got_present (r_got_present),
        .o_res         (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid       = r_v4;
    assign o_res.new_value   = r_res.new_value;
    assign o_res.write_width = r_res.write_width;
    assign o_res.status      = r_res.status;

    a_no_write_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_res.status != ST_PATCHED) |->
        (r_res.new_value == 64'd0 && r_res.write_width == WW_NONE))
        else $error("Result without a patch carries a value or a width.");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_v1 && !r_v2 && !r_v3 && !r_v4))
        else $error("Pipeline holds a word after reset.");

    a_stage3_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_v4 && !o_res.ready) |=> (r_v3 && $stable(r_s3_t) && $stable(r_s3_d)))
        else $error("Stage three changed while the output was stalled.");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v1 || !r_v2 || !r_v3 || !r_v4) |-> i_rel.ready)
        else $error("Input not ready although a stage is empty.");

endmodule

FILE: sv/arp_fmt.sv
// Result formatter: builds the patched value, write width and status of one word.
module arp_fmt
    import arp_pkg::*;
(
    input  logic [4:0]  i_cmd,
    input  logic [63:0] i_t,
    input  logic [63:0] i_d,
    input  logic [31:0] i_old,
    input  logic        i_got_present,
    output t_res        o_res
);

    logic [31:0] w;
    logic        is_word;
    logic [4:0]  sh;
    logic [63:0] t_sh;
    logic [11:0] lo12;

    always_comb begin
        w       = '0;
        is_word = 1'b0;
        o_res   = '{new_value: '0, write_width: WW_NONE, status: ST_PATCHED};
        sh      = '0;
        t_sh    = '0;
        lo12    = '0;
        case (i_cmd)
            CMD_ABS64, CMD_TPREL64: begin
                o_res.new_value   = i_t;
                o_res.write_width = WW_64;
            end
            CMD_ABS32: begin
                o_res.new_value   = {32'd0, i_t[31:0]};
                o_res.write_width = WW_32;
            end
            CMD_ABS16: begin
                o_res.new_value   = {48'd0, i_t[15:0]};
                o_res.write_width = WW_16;
            end
            CMD_PREL64: begin
                o_res.new_value   = i_d;
                o_res.write_width = WW_64;
            end
            CMD_PREL32: begin
                o_res.new_value   = {32'd0, i_d[31:0]};
                o_res.write_width = WW_32;
            end
            CMD_PREL16: begin
                o_res.new_value   = {48'd0, i_d[15:0]};
                o_res.write_width = WW_16;
            end
            CMD_TP_G2: begin
                w       = {i_old[31:21], i_t[47:32], i_old[4:0]};
                is_word = 1'b1;
            end
            CMD_TP_G1: begin
                w       = {i_old[31:21], i_t[31:16], i_old[4:0]};
                is_word = 1'b1;
            end
            CMD_TP_G0: begin
                w       = {i_old[31:21], i_t[15:0], i_old[4:0]};
                is_word = 1'b1;
            end
            CMD_TP_HI12: begin
                w       = {i_old[31:22], i_t[23:12], i_old[9:0]};
                is_word = 1'b1;
            end
            CMD_TP_LO12_S0, CMD_TP_LO12_S1, CMD_TP_LO12_S2, CMD_TP_LO12_S3,
            CMD_TP_LO12_S4: begin
                sh      = i_cmd - CMD_TP_LO12_S0;
                t_sh    = i_t >> sh[2:0];
                w       = {i_old[31:22], t_sh[11:0], i_old[9:0]};
                is_word = 1'b1;
            end
            CMD_ADR_LO21: begin
                w       = {i_old[31], i_d[1:0], i_old[28:24], i_d[20:2], i_old[4:0]};
                is_word = 1'b1;
            end
            CMD_ADRP: begin
                w       = {1'b1, i_d[13:12], 5'b10000, i_d[32:14], i_old[4:0]};
                is_word = 1'b1;
            end
            CMD_GOT_PAGE: begin
                if (i_got_present) begin
                    w       = {1'b1, i_d[13:12], 5'b10000, i_d[32:14], i_old[4:0]};
                    is_word = 1'b1;
                end else begin
                    o_res.status = ST_NO_GOT;
                end
            end
            CMD_ADD_LO12: begin
                w       = {i_old[31:22], i_t[11:0], i_old[9:0]};
                is_word = 1'b1;
            end
            CMD_LDST_S0, CMD_LDST_S1, CMD_LDST_S2, CMD_LDST_S3, CMD_LDST_S4: begin
                sh      = i_cmd - CMD_LDST_S0;
                lo12    = i_t[11:0] >> sh[2:0];
                w       = {i_old[31:22], lo12, i_old[9:0]};
                is_word = 1'b1;
            end
            CMD_BRANCH26, CMD_CALL_PLT: begin
                w       = {i_old[31:26], i_d[27:2]};
                is_word = 1'b1;
            end
            CMD_NOP: begin
                o_res.status = ST_DONE;
            end
            default: begin
                o_res.status = ST_UNSUP;
            end
        endcase
        if (is_word) begin
            o_res.new_value   = {32'd0, w};
            o_res.write_width = WW_32;
        end
    end

endmodule
